/* rtl/perlin_noise_height_assert.svh */
// Assertion macros for the checker of the height sampler.
// No dependencies; take in with `include inside a module body.
`ifndef PERLIN_NOISE_HEIGHT_ASSERT_SVH
`define PERLIN_NOISE_HEIGHT_ASSERT_SVH

// Plain property, sampled on clk, off while in reset.
`define PNH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define PNH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PNH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pnh_pkg.sv */
// Shared types, constants and arithmetic helpers of the height sampler.
// No dependencies; used by every module of the block.
`default_nettype none

package pnh_pkg;

    // pipeline stages, index = stage that loads on ld[index]
    localparam int NSTG      = 7;
    localparam int STG_SCALE = 0;
    localparam int STG_CELL  = 1;
    localparam int STG_HASH  = 2;
    localparam int STG_DOT   = 3;
    localparam int STG_LERPX = 4;
    localparam int STG_LERPY = 5;
    localparam int STG_OUT   = 6;

    localparam int FREQ_W   = 24;
    localparam int AMP_W    = 19;
    localparam int SEED_W   = 32;
    localparam int POS_W    = 32;
    localparam int HEIGHT_W = 20;
    localparam int CELL_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int FADE_W   = 17;
    localparam int DOT_W    = 19;
    localparam int NOISE_W  = 20;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd838861;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 19'd65536;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd0;

    // hash multipliers; the z and mix multipliers only matter in their low 18 bits
    localparam logic [31:0] HASH_KX    = 32'h27d4eb2d;
    localparam logic [17:0] HASH_KZ_LO = 18'h267b1;
    localparam logic [17:0] HASH_KM_LO = 18'h379b9;

    localparam logic signed [17:0] ONE_Q16  = 18'sd65536;
    localparam logic signed [17:0] DIAG_Q16 = 18'sd46341;

    typedef enum logic [1:0] {
        CFG_FREQUENCY = 2'd0,
        CFG_AMPLITUDE = 2'd1,
        CFG_SEED      = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        GS_ZERO     = 3'd0,
        GS_POS_ONE  = 3'd1,
        GS_NEG_ONE  = 3'd2,
        GS_POS_DIAG = 3'd3,
        GS_NEG_DIAG = 3'd4
    } grad_sel_t;

    typedef struct packed {
        logic [NSTG-1:0] ld;
    } pipe_ctl_t;

    function automatic grad_sel_t grad_x_sel(input logic [2:0] g);
        grad_sel_t s;
        unique case (g)
            3'd0:    s = GS_POS_ONE;
            3'd1:    s = GS_NEG_ONE;
            3'd2:    s = GS_ZERO;
            3'd3:    s = GS_ZERO;
            3'd4:    s = GS_POS_DIAG;
            3'd5:    s = GS_NEG_DIAG;
            3'd6:    s = GS_POS_DIAG;
            default: s = GS_NEG_DIAG;
        endcase
        return s;
    endfunction

    function automatic grad_sel_t grad_z_sel(input logic [2:0] g);
        grad_sel_t s;
        unique case (g)
            3'd0:    s = GS_ZERO;
            3'd1:    s = GS_ZERO;
            3'd2:    s = GS_POS_ONE;
            3'd3:    s = GS_NEG_ONE;
            3'd4:    s = GS_POS_DIAG;
            3'd5:    s = GS_POS_DIAG;
            3'd6:    s = GS_NEG_DIAG;
            default: s = GS_NEG_DIAG;
        endcase
        return s;
    endfunction

    // gradient component times offset, floor of product >> 16;
    // p is the precomputed diagonal product DIAG_Q16 * d
    function automatic logic signed [17:0] grad_term(input grad_sel_t sel,
                                                     input logic signed [17:0] d,
                                                     input logic signed [33:0] p);
        logic signed [34:0] np;
        logic signed [17:0] r;
        np = 35'sd0 - 35'(p);
        unique case (sel)
            GS_ZERO:     r = 18'sd0;
            GS_POS_ONE:  r = d;
            GS_NEG_ONE:  r = 18'sd0 - d;
            GS_POS_DIAG: r = 18'(p >>> 16);
            GS_NEG_DIAG: r = 18'(np >>> 16);
            default:     r = 18'sd0;
        endcase
        return r;
    endfunction

    // a + floor((b - a) * w >> 16)
    function automatic logic signed [NOISE_W-1:0] lerp_q16(input logic signed [NOISE_W-1:0] a,
                                                           input logic signed [NOISE_W-1:0] b,
                                                           input logic [FADE_W-1:0] w);
        logic signed [NOISE_W:0]          d;
        logic signed [NOISE_W+FADE_W+1:0] pr;
        logic signed [NOISE_W+2:0]        s;
        d  = (NOISE_W+1)'(b) - (NOISE_W+1)'(a);
        pr = d * $signed({1'b0, w});
        s  = (NOISE_W+3)'(a) + (NOISE_W+3)'(pr >>> 16);
        return NOISE_W'(s);
    endfunction

endpackage

`default_nettype wire

/* rtl/perlin_noise_height.sv */
// Top level of the 2D gradient-noise height sampler: ports, config registers,
// coordinate scaling and pipeline flow control. Depends on pnh_pkg, pnh_hash,
// pnh_fade and pnh_blend.
//
// Usage:
//   s_axis carries one world position per transaction, pos_x and pos_z as
//   signed Q16.16. m_axis returns one height per position, signed Q3.16,
//   in the same order. The cfg channel writes frequency (index 0), amplitude
//   (index 1) or seed (index 2); other indexes are dropped. cfg_ready is
//   always high. Write config only while no position is in flight.
//   The pipeline has seven register stages (scale multiply, cell products,
//   hash mix, dot products, x lerp, z lerp, amplitude scale and clamp), each
//   holding one multiplier level. Throughput is one position per clock
//   while m_axis_tready stays high. A position reaches m_axis_tvalid after
//   passing through every stage register in order.
//   Each stage has its own valid bit and loads when it is empty or its
//   successor loads, so bubbles are squeezed out; while m_axis_tready is low
//   the pipeline keeps taking positions until all seven stages are full.
//   Reset empties the pipeline and loads frequency 0.05, amplitude 1.0, seed 0.
`default_nettype none

module perlin_noise_height (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] pos_x, [63:32] pos_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [19:0] height, [23:20] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pnh_pkg::*;

    logic [FREQ_W-1:0]         frequency_reg;
    logic [AMP_W-1:0]          amplitude_reg;
    logic [SEED_W-1:0]         seed_reg;
    logic [NSTG-1:0]           valid_reg;
    logic [NSTG-1:0]           valid_next;
    pipe_ctl_t                 ctl;
    logic signed [56:0]        sx_full;
    logic signed [56:0]        sz_full;
    logic [55:0]               sx_reg;
    logic [55:0]               sz_reg;
    logic [3:0][2:0]           corner_grad;
    logic [FADE_W-1:0]         fade_x;
    logic [FADE_W-1:0]         fade_z;
    logic [HEIGHT_W-1:0]       height;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frequency_reg <= FREQ_RESET;
            amplitude_reg <= AMP_RESET;
            seed_reg      <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FREQUENCY: frequency_reg <= cfg_data[FREQ_W-1:0];
                CFG_AMPLITUDE: amplitude_reg <= cfg_data[AMP_W-1:0];
                CFG_SEED:      seed_reg      <= cfg_data[SEED_W-1:0];
                default:       ;
            endcase
        end
    end

    // a stage loads when empty or when the stage after it loads
    always_comb
    begin
        ctl.ld[NSTG-1] = !valid_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG-2; k >= 0; k--)
        begin
            ctl.ld[k] = !valid_reg[k] || ctl.ld[k+1];
        end
        valid_next[0] = ctl.ld[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            valid_next[k] = ctl.ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // scaled coordinate, signed Q16.40; fits 56 bits
    assign sx_full = $signed(s_axis_tdata[POS_W-1:0]) * $signed({1'b0, frequency_reg});
    assign sz_full = $signed(s_axis_tdata[2*POS_W-1:POS_W]) * $signed({1'b0, frequency_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.ld[STG_SCALE])
        begin
            sx_reg <= sx_full[55:0];
            sz_reg <= sz_full[55:0];
        end
    end

    pnh_hash u_hash (
        .clk         (clk),
        .ctl         (ctl),
        .cell_x      (sx_reg[55:40]),
        .cell_z      (sz_reg[55:40]),
        .seed        (seed_reg),
        .corner_grad (corner_grad)
    );

    pnh_fade u_fade_x (
        .clk  (clk),
        .ctl  (ctl),
        .t    (sx_reg[39:24]),
        .fade (fade_x)
    );

    pnh_fade u_fade_z (
        .clk  (clk),
        .ctl  (ctl),
        .t    (sz_reg[39:24]),
        .fade (fade_z)
    );

    pnh_blend u_blend (
        .clk         (clk),
        .ctl         (ctl),
        .t_x         (sx_reg[39:24]),
        .t_z         (sz_reg[39:24]),
        .corner_grad (corner_grad),
        .fade_x      (fade_x),
        .fade_z      (fade_z),
        .amplitude   (amplitude_reg),
        .height      (height)
    );

    assign s_axis_tready = ctl.ld[STG_SCALE];
    assign m_axis_tvalid = valid_reg[STG_OUT];
    assign m_axis_tdata  = {4'b0, height};

endmodule

`default_nettype wire

/* rtl/pnh_hash.sv */
// Corner hash pipeline: cell coordinates and seed to four 3-bit gradient codes.
// Depends on pnh_pkg; stages CELL and HASH, codes read from the HASH registers.
`default_nettype none

module pnh_hash (
    input  logic                           clk,
    input  pnh_pkg::pipe_ctl_t             ctl,
    input  logic [pnh_pkg::CELL_W-1:0]     cell_x,
    input  logic [pnh_pkg::CELL_W-1:0]     cell_z,
    input  logic [pnh_pkg::SEED_W-1:0]     seed,
    output logic [3:0][2:0]                corner_grad
);
    import pnh_pkg::*;

    logic [31:0]       cx;
    logic [31:0]       cx1;
    logic [17:0]       cz_lo;
    logic [17:0]       cz1_lo;
    logic [1:0][31:0]  mx_next;
    logic [1:0][31:0]  mx_reg;
    logic [1:0][17:0]  mz_next;
    logic [1:0][17:0]  mz_reg;
    logic [3:0][17:0]  mix_next;
    logic [3:0][17:0]  mix_reg;

    // cell products, x needs all 32 bits because of the half swap
    always_comb
    begin
        cx         = {{(32-CELL_W){cell_x[CELL_W-1]}}, cell_x};
        cx1        = cx + 32'd1;
        cz_lo      = {{(18-CELL_W){cell_z[CELL_W-1]}}, cell_z};
        cz1_lo     = cz_lo + 18'd1;
        mx_next[0] = cx * HASH_KX;
        mx_next[1] = cx1 * HASH_KX;
        mz_next[0] = cz_lo * HASH_KZ_LO;
        mz_next[1] = cz1_lo * HASH_KZ_LO;
    end

    // xor seed, swap halves, xor z product, final multiply; low 18 bits suffice
    always_comb
    begin
        logic [31:0] u;
        logic [17:0] lo;
        logic [1:0]  cc;
        u  = '0;
        lo = '0;
        cc = '0;
        for (int c = 0; c < 4; c++)
        begin
            cc          = 2'(c);
            u           = seed ^ mx_reg[cc[0]];
            lo          = {u[1:0], u[31:16]} ^ mz_reg[cc[1]];
            mix_next[c] = lo * HASH_KM_LO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[STG_CELL])
        begin
            mx_reg <= mx_next;
            mz_reg <= mz_next;
        end
        if (ctl.ld[STG_HASH])
        begin
            mix_reg <= mix_next;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            corner_grad[c] = mix_reg[c][2:0] ^ mix_reg[c][17:15];
        end
    end

endmodule

`default_nettype wire

/* rtl/pnh_fade.sv */
// Quintic fade of one Q0.16 fraction, one product per stage after CELL.
// Depends on pnh_pkg; stages CELL, HASH and DOT, result from the DOT register.
`default_nettype none

module pnh_fade (
    input  logic                         clk,
    input  pnh_pkg::pipe_ctl_t           ctl,
    input  logic [pnh_pkg::FRAC_W-1:0]   t,
    output logic [pnh_pkg::FADE_W-1:0]   fade
);
    import pnh_pkg::*;

    logic [31:0]              tt;
    logic signed [20:0]       q;
    logic signed [37:0]       pr;
    logic signed [21:0]       inner_sum;
    logic [FRAC_W-1:0]        t2_next;
    logic [19:0]              inner_next;
    logic [FRAC_W-1:0]        t2_reg;
    logic [FRAC_W-1:0]        t_s2_reg;
    logic [19:0]              inner_reg;
    logic [31:0]              p3;
    logic [FRAC_W-1:0]        t3_reg;
    logic [19:0]              inner_s3_reg;
    logic [35:0]              pf;
    logic [FADE_W-1:0]        fade_reg;

    // t*t and t*(6t - 15) + 10, the inner term is always positive
    always_comb
    begin
        tt         = t * t;
        t2_next    = tt[31:16];
        q          = $signed({5'b0, t}) * 21'sd6 - 21'sd983040;
        pr         = $signed({1'b0, t}) * q;
        inner_sum  = 22'(pr >>> 16) + 22'sd655360;
        inner_next = inner_sum[19:0];
    end

    assign p3 = t2_reg * t_s2_reg;
    assign pf = t3_reg * inner_s3_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ld[STG_CELL])
        begin
            t2_reg    <= t2_next;
            t_s2_reg  <= t;
            inner_reg <= inner_next;
        end
        if (ctl.ld[STG_HASH])
        begin
            t3_reg       <= p3[31:16];
            inner_s3_reg <= inner_reg;
        end
        if (ctl.ld[STG_DOT])
        begin
            fade_reg <= pf[32:16];
        end
    end

    assign fade = fade_reg;

endmodule

`default_nettype wire

/* rtl/pnh_blend.sv */
// Corner dot products, the three lerps, amplitude scale and clamp.
// Depends on pnh_pkg; stages CELL through OUT, height from the OUT register.
`default_nettype none

module pnh_blend (
    input  logic                           clk,
    input  pnh_pkg::pipe_ctl_t             ctl,
    input  logic [pnh_pkg::FRAC_W-1:0]     t_x,
    input  logic [pnh_pkg::FRAC_W-1:0]     t_z,
    input  logic [3:0][2:0]                corner_grad,
    input  logic [pnh_pkg::FADE_W-1:0]     fade_x,
    input  logic [pnh_pkg::FADE_W-1:0]     fade_z,
    input  logic [pnh_pkg::AMP_W-1:0]      amplitude,
    output logic [pnh_pkg::HEIGHT_W-1:0]   height
);
    import pnh_pkg::*;

    logic [FRAC_W-1:0]           tx2_reg;
    logic [FRAC_W-1:0]           tz2_reg;
    logic signed [17:0]          dx_next [2];
    logic signed [17:0]          dz_next [2];
    logic signed [33:0]          px_next [2];
    logic signed [33:0]          pz_next [2];
    logic signed [17:0]          dx_reg  [2];
    logic signed [17:0]          dz_reg  [2];
    logic signed [33:0]          px_reg  [2];
    logic signed [33:0]          pz_reg  [2];
    logic signed [DOT_W-1:0]     dot_next [4];
    logic signed [DOT_W-1:0]     dot_reg  [4];
    logic signed [NOISE_W-1:0]   nx_next [2];
    logic signed [NOISE_W-1:0]   nx_reg  [2];
    logic [FADE_W-1:0]           fz5_reg;
    logic signed [NOISE_W-1:0]   n_next;
    logic signed [NOISE_W-1:0]   n_reg;
    logic signed [39:0]          amp_prod;
    logic signed [23:0]          h_raw;
    logic signed [23:0]          amp_s;
    logic [HEIGHT_W-1:0]         height_next;
    logic [HEIGHT_W-1:0]         height_reg;

    // corner offsets and their diagonal products
    always_comb
    begin
        dx_next[0] = $signed({2'b0, tx2_reg});
        dx_next[1] = dx_next[0] - ONE_Q16;
        dz_next[0] = $signed({2'b0, tz2_reg});
        dz_next[1] = dz_next[0] - ONE_Q16;
        for (int i = 0; i < 2; i++)
        begin
            px_next[i] = DIAG_Q16 * dx_next[i];
            pz_next[i] = DIAG_Q16 * dz_next[i];
        end
    end

    // corner c carries x offset in bit 0, z offset in bit 1
    always_comb
    begin
        logic [1:0] cc;
        cc = '0;
        for (int c = 0; c < 4; c++)
        begin
            cc          = 2'(c);
            dot_next[c] =
                DOT_W'(grad_term(grad_x_sel(corner_grad[c]), dx_reg[cc[0]], px_reg[cc[0]]))
              + DOT_W'(grad_term(grad_z_sel(corner_grad[c]), dz_reg[cc[1]], pz_reg[cc[1]]));
        end
    end

    always_comb
    begin
        nx_next[0] = lerp_q16(NOISE_W'(dot_reg[0]), NOISE_W'(dot_reg[1]), fade_x);
        nx_next[1] = lerp_q16(NOISE_W'(dot_reg[2]), NOISE_W'(dot_reg[3]), fade_x);
        n_next     = lerp_q16(nx_reg[0], nx_reg[1], fz5_reg);
    end

    // scale by amplitude, clamp to plus or minus amplitude
    always_comb
    begin
        amp_prod = n_reg * $signed({1'b0, amplitude});
        h_raw    = 24'(amp_prod >>> 16);
        amp_s    = $signed({5'b0, amplitude});
        priority if (h_raw > amp_s)
        begin
            height_next = HEIGHT_W'(amp_s);
        end
        else if (h_raw < -amp_s)
        begin
            height_next = HEIGHT_W'(-amp_s);
        end
        else
        begin
            height_next = HEIGHT_W'(h_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[STG_CELL])
        begin
            tx2_reg <= t_x;
            tz2_reg <= t_z;
        end
        if (ctl.ld[STG_HASH])
        begin
            dx_reg <= dx_next;
            dz_reg <= dz_next;
            px_reg <= px_next;
            pz_reg <= pz_next;
        end
        if (ctl.ld[STG_DOT])
        begin
            dot_reg <= dot_next;
        end
        if (ctl.ld[STG_LERPX])
        begin
            nx_reg  <= nx_next;
            fz5_reg <= fade_z;
        end
        if (ctl.ld[STG_LERPY])
        begin
            n_reg <= n_next;
        end
        if (ctl.ld[STG_OUT])
        begin
            height_reg <= height_next;
        end
    end

    assign height = height_reg;

endmodule

`default_nettype wire

/* rtl/pnh_checker.sv */
// Port-level checker of the height sampler, bound to the top level.
// Depends on pnh_pkg and perlin_noise_height_assert.svh.
`default_nettype none

module pnh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pnh_pkg::*;
    `include "perlin_noise_height_assert.svh"

    logic [3:0]                 inflight_reg;
    logic [3:0]                 inflight_next;
    logic [AMP_W-1:0]           amp_reg;
    logic signed [HEIGHT_W-1:0] h_s;
    logic signed [HEIGHT_W-1:0] amp_s;

    // count transactions in flight between the two sides
    always_comb
    begin
        inflight_next = inflight_reg
                      + 4'(s_axis_tvalid && s_axis_tready)
                      - 4'(m_axis_tvalid && m_axis_tready);
    end

    // in-flight counter and shadow of the amplitude register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            amp_reg      <= AMP_RESET;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (cfg_valid && cfg_ready && cfg_idx_t'(cfg_index) == CFG_AMPLITUDE)
            begin
                amp_reg <= cfg_data[AMP_W-1:0];
            end
        end
    end

    assign h_s   = $signed(m_axis_tdata[HEIGHT_W-1:0]);
    assign amp_s = $signed({1'b0, amp_reg});

    `PNH_ASSERT(a_inflight_bound, inflight_reg <= 4'(NSTG), "more items in flight than stages")
    `PNH_ASSERT_IMP(a_no_spurious, m_axis_tvalid, inflight_reg != 4'd0, "result without input")
    `PNH_ASSERT_IMP(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
    `PNH_ASSERT_IMP(a_height_clamped, m_axis_tvalid, (h_s <= amp_s) && (h_s >= -amp_s), "height beyond amplitude")
    `PNH_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind perlin_noise_height pnh_checker u_pnh_checker (.*);

`default_nettype wire
